/* rtl/core/mtep_pkg.sv */
package mtep_pkg;

  // longest variable-length quantity, in bytes
  localparam int MAX_VLQ_BYTES = 4;

  localparam logic [7:0] DATA_MASK     = 8'h7f;
  localparam logic [7:0] STATUS_MIN    = 8'h80;
  localparam logic [7:0] SYSTEM_MIN    = 8'hf0;
  localparam logic [7:0] SYSEX_START   = 8'hf0;
  localparam logic [7:0] SYSEX_ESCAPE  = 8'hf7;
  localparam logic [7:0] SONG_POSITION = 8'hf2;
  localparam logic [7:0] TIME_CODE     = 8'hf1;
  localparam logic [7:0] SONG_SELECT   = 8'hf3;
  localparam logic [7:0] META_PREFIX   = 8'hff;
  localparam logic [7:0] META_TRACK_END = 8'h2f;
  localparam logic [7:0] META_TEMPO    = 8'h51;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_END     = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_CHANNEL   = 2'd0,
    EV_SYSEX     = 2'd1,
    EV_TEMPO     = 2'd2,
    EV_TRACK_END = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    PH_DELTA    = 3'd0,
    PH_EVENT    = 3'd1,
    PH_DATA     = 3'd2,
    PH_SYSLEN   = 3'd3,
    PH_METATYPE = 3'd4,
    PH_METALEN  = 3'd5,
    PH_PAYLOAD  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    PK_NEW     = 3'd0,
    PK_RUNNING = 3'd1,
    PK_COMMON  = 3'd2,
    PK_META    = 3'd3,
    PK_TEMPO   = 3'd4,
    PK_SYSEX   = 3'd5
  } pending_t;

  typedef struct packed {
    phase_t      parse_phase;
    logic [27:0] vlq_accum;
    logic [2:0]  vlq_bytes;
    logic [27:0] skip_remaining;
    logic [7:0]  running_status;
    logic [1:0]  running_size;
    pending_t    pending_kind;
    logic [15:0] data_held;
    logic [1:0]  bytes_wanted;
    logic [31:0] delta_sum;
    logic [31:0] tick_clock;
    logic [31:0] tempo_accum;
    logic        track_done;
  } parse_state_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [31:0] delta_ticks;
    logic [31:0] event_clock;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [1:0]  data_count;
    logic        used_running;
    logic [31:0] tempo_value;
    logic [27:0] sysex_length;
  } event_t;

endpackage

/* rtl/core/mtep_in_if.sv */
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

/* rtl/core/mtep_out_if.sv */
interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] delta_ticks;
  logic [31:0] event_clock;
  logic [7:0]  status_byte;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [1:0]  data_count;
  logic        used_running;
  logic [31:0] tempo_value;
  logic [27:0] sysex_length;

  modport source (
    output valid, output event_kind, output delta_ticks, output event_clock,
    output status_byte, output first_data, output second_data, output data_count,
    output used_running, output tempo_value, output sysex_length, input ready
  );
  modport sink (
    input valid, input event_kind, input delta_ticks, input event_clock,
    input status_byte, input first_data, input second_data, input data_count,
    input used_running, input tempo_value, input sysex_length, output ready
  );
endinterface

/* rtl/core/mtep_step.sv */
module mtep_step #(
  parameter int MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES
) (
  input  mtep_pkg::parse_state_t state,
  input  logic [1:0]             action,
  input  logic [7:0]             data_byte,
  output mtep_pkg::parse_state_t state_next,
  output logic                   result_valid,
  output mtep_pkg::event_t       result
);

  // channel event built from the status in effect and the held data bytes
  function automatic mtep_pkg::event_t channel_event(
    input mtep_pkg::parse_state_t s,
    input logic [15:0]            held
  );
    mtep_pkg::event_t e;
    e = '0;
    e.event_kind   = mtep_pkg::EV_CHANNEL;
    e.delta_ticks  = s.delta_sum;
    e.event_clock  = s.tick_clock;
    e.status_byte  = s.running_status;
    e.first_data   = (s.running_size > 2'd0) ? held[6:0] : 7'd0;
    e.second_data  = (s.running_size > 2'd1) ? held[14:8] : 7'd0;
    e.data_count   = s.running_size;
    e.used_running = (s.pending_kind == mtep_pkg::PK_RUNNING);
    return e;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [27:0] acc_new;
    logic [2:0]  cnt_new;
    logic        vlq_done;
    logic [15:0] held_new;
    logic [27:0] skip_new;
    logic [31:0] tempo_new;
    mtep_pkg::event_t base;

    b         = data_byte;
    acc_new   = {state.vlq_accum[20:0], b[6:0]};
    cnt_new   = state.vlq_bytes + 3'd1;
    vlq_done  = !b[7] || (cnt_new >= 3'(MAX_VLQ_BYTES));
    held_new  = (state.running_size == state.bytes_wanted) ? {8'h00, b}
                                                           : {b, state.data_held[7:0]};
    skip_new  = (state.skip_remaining != 28'd0) ? state.skip_remaining - 28'd1 : 28'd0;
    tempo_new = {state.tempo_accum[23:0], b};

    base             = '0;
    base.delta_ticks = state.delta_sum;
    base.event_clock = state.tick_clock;

    state_next   = state;
    result_valid = 1'b0;
    result       = base;

    if (action == mtep_pkg::ACT_RESTART) begin
      state_next.track_done     = 1'b0;
      state_next.tick_clock     = 32'd0;
      state_next.delta_sum      = 32'd0;
      state_next.skip_remaining = 28'd0;
      state_next.bytes_wanted   = 2'd0;
      state_next.vlq_accum      = 28'd0;
      state_next.vlq_bytes      = 3'd0;
      state_next.parse_phase    = mtep_pkg::PH_DELTA;
    end else if (action == mtep_pkg::ACT_NONE || state.track_done) begin
      // nothing to do
    end else if (action == mtep_pkg::ACT_END) begin
      result_valid           = 1'b1;
      result.event_kind      = mtep_pkg::EV_TRACK_END;
      state_next.delta_sum   = 32'd0;
      state_next.track_done  = 1'b1;
      state_next.vlq_accum   = 28'd0;
      state_next.vlq_bytes   = 3'd0;
      state_next.parse_phase = mtep_pkg::PH_DELTA;
    end else begin
      unique case (state.parse_phase)
        mtep_pkg::PH_DELTA: begin
          state_next.vlq_accum = acc_new;
          state_next.vlq_bytes = cnt_new;
          if (vlq_done) begin
            state_next.delta_sum   = state.delta_sum + 32'(acc_new);
            state_next.tick_clock  = state.tick_clock + 32'(acc_new);
            state_next.vlq_accum   = 28'd0;
            state_next.vlq_bytes   = 3'd0;
            state_next.parse_phase = mtep_pkg::PH_EVENT;
          end
        end

        mtep_pkg::PH_EVENT: begin
          priority if (b < mtep_pkg::STATUS_MIN) begin
            if (state.running_status == 8'd0) begin
              // stray data byte, no status to run on
              state_next.vlq_accum   = 28'd0;
              state_next.vlq_bytes   = 3'd0;
              state_next.parse_phase = mtep_pkg::PH_DELTA;
            end else begin
              state_next.pending_kind = mtep_pkg::PK_RUNNING;
              state_next.data_held    = {8'h00, b};
              if (state.running_size <= 2'd1) begin
                result_valid = 1'b1;
                result = channel_event(state_next, {8'h00, b});
                state_next.delta_sum   = 32'd0;
                state_next.vlq_accum   = 28'd0;
                state_next.vlq_bytes   = 3'd0;
                state_next.parse_phase = mtep_pkg::PH_DELTA;
              end else begin
                state_next.bytes_wanted = state.running_size - 2'd1;
                state_next.parse_phase  = mtep_pkg::PH_DATA;
              end
            end
          end else if (b < mtep_pkg::SYSTEM_MIN) begin
            state_next.running_status = b;
            state_next.running_size   = (b[6:4] == 3'd4 || b[6:4] == 3'd5) ? 2'd1 : 2'd2;
            state_next.bytes_wanted   = (b[6:4] == 3'd4 || b[6:4] == 3'd5) ? 2'd1 : 2'd2;
            state_next.pending_kind   = mtep_pkg::PK_NEW;
            state_next.data_held      = 16'd0;
            state_next.parse_phase    = mtep_pkg::PH_DATA;
          end else if (b == mtep_pkg::SYSEX_START || b == mtep_pkg::SYSEX_ESCAPE) begin
            state_next.vlq_accum   = 28'd0;
            state_next.vlq_bytes   = 3'd0;
            state_next.parse_phase = mtep_pkg::PH_SYSLEN;
          end else if (b == mtep_pkg::TIME_CODE || b == mtep_pkg::SONG_SELECT ||
                       b == mtep_pkg::SONG_POSITION) begin
            state_next.pending_kind = mtep_pkg::PK_COMMON;
            state_next.bytes_wanted = (b == mtep_pkg::SONG_POSITION) ? 2'd2 : 2'd1;
            state_next.parse_phase  = mtep_pkg::PH_DATA;
          end else if (b == mtep_pkg::META_PREFIX) begin
            state_next.parse_phase = mtep_pkg::PH_METATYPE;
          end else begin
            // other system common and real-time bytes
            state_next.vlq_accum   = 28'd0;
            state_next.vlq_bytes   = 3'd0;
            state_next.parse_phase = mtep_pkg::PH_DELTA;
          end
        end

        mtep_pkg::PH_DATA: begin
          if (state.pending_kind == mtep_pkg::PK_COMMON) begin
            if (state.bytes_wanted <= 2'd1) begin
              state_next.vlq_accum   = 28'd0;
              state_next.vlq_bytes   = 3'd0;
              state_next.parse_phase = mtep_pkg::PH_DELTA;
            end else begin
              state_next.bytes_wanted = state.bytes_wanted - 2'd1;
            end
          end else begin
            state_next.data_held = held_new;
            if (state.bytes_wanted <= 2'd1) begin
              result_valid = 1'b1;
              result = channel_event(state, held_new);
              state_next.delta_sum   = 32'd0;
              state_next.vlq_accum   = 28'd0;
              state_next.vlq_bytes   = 3'd0;
              state_next.parse_phase = mtep_pkg::PH_DELTA;
            end else begin
              state_next.bytes_wanted = state.bytes_wanted - 2'd1;
            end
          end
        end

        mtep_pkg::PH_SYSLEN: begin
          state_next.vlq_accum = acc_new;
          state_next.vlq_bytes = cnt_new;
          if (vlq_done) begin
            result_valid               = 1'b1;
            result.event_kind          = mtep_pkg::EV_SYSEX;
            result.sysex_length        = acc_new;
            state_next.delta_sum       = 32'd0;
            state_next.skip_remaining  = acc_new;
            state_next.pending_kind    = mtep_pkg::PK_SYSEX;
            state_next.vlq_accum       = 28'd0;
            state_next.vlq_bytes       = 3'd0;
            state_next.parse_phase     = (acc_new != 28'd0) ? mtep_pkg::PH_PAYLOAD
                                                            : mtep_pkg::PH_DELTA;
          end
        end

        mtep_pkg::PH_METATYPE: begin
          state_next.vlq_accum = 28'd0;
          state_next.vlq_bytes = 3'd0;
          if (b == mtep_pkg::META_TRACK_END) begin
            result_valid           = 1'b1;
            result.event_kind      = mtep_pkg::EV_TRACK_END;
            state_next.delta_sum   = 32'd0;
            state_next.track_done  = 1'b1;
            state_next.parse_phase = mtep_pkg::PH_DELTA;
          end else begin
            state_next.pending_kind = (b == mtep_pkg::META_TEMPO) ? mtep_pkg::PK_TEMPO
                                                                   : mtep_pkg::PK_META;
            state_next.parse_phase  = mtep_pkg::PH_METALEN;
          end
        end

        mtep_pkg::PH_METALEN: begin
          state_next.vlq_accum = acc_new;
          state_next.vlq_bytes = cnt_new;
          if (vlq_done) begin
            state_next.skip_remaining = acc_new;
            state_next.tempo_accum    = 32'd0;
            state_next.vlq_accum      = 28'd0;
            state_next.vlq_bytes      = 3'd0;
            if (acc_new == 28'd0) begin
              state_next.parse_phase = mtep_pkg::PH_DELTA;
              if (state.pending_kind == mtep_pkg::PK_TEMPO) begin
                result_valid         = 1'b1;
                result.event_kind    = mtep_pkg::EV_TEMPO;
                state_next.delta_sum = 32'd0;
              end
            end else begin
              state_next.parse_phase = mtep_pkg::PH_PAYLOAD;
            end
          end
        end

        mtep_pkg::PH_PAYLOAD: begin
          if (state.pending_kind == mtep_pkg::PK_TEMPO) begin
            state_next.tempo_accum = tempo_new;
          end
          state_next.skip_remaining = skip_new;
          if (skip_new == 28'd0) begin
            state_next.vlq_accum   = 28'd0;
            state_next.vlq_bytes   = 3'd0;
            state_next.parse_phase = mtep_pkg::PH_DELTA;
            if (state.pending_kind == mtep_pkg::PK_TEMPO) begin
              result_valid         = 1'b1;
              result.event_kind    = mtep_pkg::EV_TEMPO;
              result.tempo_value   = tempo_new;
              state_next.delta_sum = 32'd0;
            end
          end
        end

        default: begin
          state_next.vlq_accum   = 28'd0;
          state_next.vlq_bytes   = 3'd0;
          state_next.parse_phase = mtep_pkg::PH_DELTA;
        end
      endcase
    end
  end

endmodule

/* rtl/core/midi_track_event_parser.sv */
// channel    dir  modport  payload
// byte_in    in   sink     action[1:0], data_byte[7:0]
// event_out  out  source   event_kind, delta_ticks, event_clock, status_byte,
//                          first_data, second_data, data_count, used_running,
//                          tempo_value, sysex_length
//
// one track word per clock while byte_in.ready is high: the parse state is updated in the accepting cycle,
// and a result lands in the output register in the cycle after its word
// a word yields at most one result, so the output register alone decouples the sides
// byte_in.ready drops only while a result is held and event_out.ready is low
// rst (synchronous, active high) clears the parse state, running status and clock
module midi_track_event_parser #(
  parameter int MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES
) (
  input logic        clk,
  input logic        rst,
  mtep_in_if.sink    byte_in,
  mtep_out_if.source event_out
);

  mtep_pkg::parse_state_t state;
  mtep_pkg::parse_state_t state_next;
  mtep_pkg::event_t       step_result;
  logic                   step_valid;

  mtep_pkg::event_t       result;
  logic                   result_valid;
  logic                   in_accept;

  // next state and result for the word on the input
  mtep_step #(
    .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
  ) u_step (
    .state       (state),
    .action      (byte_in.action),
    .data_byte   (byte_in.data_byte),
    .state_next  (state_next),
    .result_valid(step_valid),
    .result      (step_result)
  );

  // the output slot is free or drains this cycle
  assign byte_in.ready = !result_valid || event_out.ready;
  assign in_accept     = byte_in.valid && byte_in.ready;

  // parse state advances only on accepted words
  // all-zero state is the delta phase with no status and a fresh pending kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_accept && step_valid) begin
      result_valid <= 1'b1;
    end else if (event_out.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && step_valid) begin
      result <= step_result;
    end
  end

  assign event_out.valid        = result_valid;
  assign event_out.event_kind   = result.event_kind;
  assign event_out.delta_ticks  = result.delta_ticks;
  assign event_out.event_clock  = result.event_clock;
  assign event_out.status_byte  = result.status_byte;
  assign event_out.first_data   = result.first_data;
  assign event_out.second_data  = result.second_data;
  assign event_out.data_count   = result.data_count;
  assign event_out.used_running = result.used_running;
  assign event_out.tempo_value  = result.tempo_value;
  assign event_out.sysex_length = result.sysex_length;

  // a held result that is not taken blocks the input
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !event_out.ready) |-> !in_accept)
    else $error("input accepted while result is stalled");

  // after track end only restart moves the parser
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (in_accept && state.track_done && byte_in.action != mtep_pkg::ACT_RESTART)
      |-> !step_valid)
    else $error("result produced after track end");

  // restart clears the clock, the delta sum and the track-end flag
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && byte_in.action == mtep_pkg::ACT_RESTART)
      |=> (state.tick_clock == 32'd0 && !state.track_done && state.delta_sum == 32'd0))
    else $error("restart left clock or flag set");

  // every reported event starts a fresh delta sum
  a_delta_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_accept && step_valid) |=> (state.delta_sum == 32'd0))
    else $error("delta sum kept after report");

  // quantity byte count stays within its limit
  a_vlq_bound: assert property (@(posedge clk) disable iff (rst)
    state.vlq_bytes < 3'(MAX_VLQ_BYTES))
    else $error("quantity byte count out of range");

endmodule
